// ===== src/hrv_pkg.sv =====
package hrv_pkg;

    // field widths
    localparam int PEAK_W   = 32;
    localparam int RATE_W   = 12;
    localparam int THR_W    = 10;
    localparam int IV_W     = 16;
    localparam int CNT_W    = 17;
    localparam int SUM_W    = 33;
    localparam int SQS_W    = 49;
    localparam int PNN_W    = 14;
    localparam int CFG_IDX_W = 2;

    // shared unit widths
    localparam int DVD_W    = 66;
    localparam int DSR_W    = 33;
    localparam int DIV_CW   = 7;
    localparam int MUL_W    = 66;
    localparam int MB_W     = 33;
    localparam int MUL_CW   = 6;
    localparam int SQ_W     = 64;
    localparam int SQ_CW    = 5;

    // constants
    localparam int MAX_INTERVALS = 65536;
    localparam int C_MS_SCALE    = 16000;
    localparam int C_PCT_SCALE   = 10000;
    localparam logic [RATE_W-1:0] RATE_RESET = 12'd360;
    localparam logic [THR_W-1:0]  THR_RESET  = 10'd50;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_THR    = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// ===== src/hrv_peak_if.sv =====
interface hrv_peak_if;
    import hrv_pkg::*;
    logic              valid;
    logic              ready;
    logic [PEAK_W-1:0] peak_sample;
    logic              last;

    modport source (output valid, output peak_sample, output last, input ready);
    modport sink   (input valid, input peak_sample, input last, output ready);
endinterface

// ===== src/hrv_stats_if.sv =====
interface hrv_stats_if;
    import hrv_pkg::*;
    logic             valid;
    logic             ready;
    logic [IV_W-1:0]  mean_rr;
    logic [IV_W-1:0]  sdnn;
    logic [IV_W-1:0]  rmssd;
    logic [CNT_W-1:0] nn50;
    logic [PNN_W-1:0] pnn50;
    logic [CNT_W-1:0] interval_count;
    logic             valid_res;
    logic             overflow;

    modport source (output valid, output mean_rr, output sdnn, output rmssd, output nn50,
                    output pnn50, output interval_count, output valid_res,
                    output overflow, input ready);
    modport sink   (input valid, input mean_rr, input sdnn, input rmssd, input nn50,
                    input pnn50, input interval_count, input valid_res,
                    input overflow, output ready);
endinterface

// ===== src/hrv_div.sv =====
module hrv_div import hrv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [DSR_W-1:0]  i_divisor,
    output t_unit_stat        o_stat,
    output logic [DVD_W-1:0]  o_quot
);
    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DSR_W:0]    r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DSR_W-1:0]  r_dsr;
    logic [DSR_W:0]    rem_sh;
    logic              ge;

    // one restoring step per cycle
    assign rem_sh = {r_rem[DSR_W-1:0], r_quo[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DVD_W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
                r_quo <= {r_quo[DVD_W-2:0], ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_div_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while still busy");
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem < {1'b0, r_dsr})
        else $error("partial remainder not below divisor");
endmodule

// ===== src/hrv_mul.sv =====
module hrv_mul import hrv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MB_W-1:0]   i_b,
    output t_unit_stat        o_stat,
    output logic [MUL_W-1:0]  o_prod
);
    logic              r_busy;
    logic              r_done;
    logic [MUL_CW-1:0] r_cnt;
    logic [MUL_W-1:0]  r_acc;
    logic [MUL_W-1:0]  r_a;
    logic [MB_W-1:0]   r_b;

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CW'(MB_W - 1);
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[MUL_W-2:0], 1'b0};
                r_b <= {1'b0, r_b[MB_W-1:1]};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;
endmodule

// ===== src/hrv_sqrt.sv =====
module hrv_sqrt import hrv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_W-1:0]  i_val,
    output t_unit_stat       o_stat,
    output logic [IV_W-1:0]  o_root
);
    logic             r_busy;
    logic             r_done;
    logic [SQ_CW-1:0] r_cnt;
    logic [SQ_W-1:0]  r_x;
    logic [SQ_W-1:0]  r_r;
    logic [SQ_W-1:0]  r_bit;
    logic [SQ_W-1:0]  trial;
    logic [SQ_W-1:0]  rounded;

    assign trial = r_r + r_bit;

    // digit-by-digit root, two radicand bits per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SQ_CW'(SQ_W / 2 - 1);
                r_x    <= i_val;
                r_r    <= '0;
                r_bit  <= SQ_W'(1) << (SQ_W - 2);
            end else if (r_busy) begin
                if (r_x >= trial) begin
                    r_x <= r_x - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // round to nearest: leftover above root means the next integer is closer
    assign rounded = r_r + SQ_W'(r_x > r_r);
    assign o_root  = (rounded > SQ_W'(16'hFFFF)) ? 16'hFFFF : rounded[IV_W-1:0];

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

// ===== src/hrv_time_domain_stats.sv =====
// Time-domain HRV statistics over one record of R-peak sample positions.
// Input channel i_peak carries one request per R peak (peak_sample, last).
// Each positive gap is converted to an RR interval in Q12.4 ms and folded
// into running sums. The request marked last closes the record: one result
// request on o_stats gives mean RR, SDNN, RMSSD, NN50, pNN50, the interval
// count and flags, then all record state clears (configuration stays).
// Configuration: i_cfg_we with i_cfg_idx 0 (sample rate) or 1 (NN50
// threshold, whole ms); write only while the block is idle.
// Timing: ready is high only in idle. A peak that makes an interval runs one
// 66-step divide on the shared divider; a peak without an interval skips it.
// A closing peak with two or more intervals adds four 66-step divides, two
// 33-step multiplies and two 32-step roots, one unit at a time.
// Results sit in an output register: the next record's peaks are taken
// while a result waits, and a following closing peak holds until the
// receiver takes the earlier result.
// Reset (synchronous, active low) clears all state, restores rate 360 Hz
// and threshold 50 ms, and drops o_stats.valid.
module hrv_time_domain_stats import hrv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hrv_peak_if.sink             i_peak,
    hrv_stats_if.source          o_stats,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [RATE_W-1:0]    i_cfg_data
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_IVMUL  = 5'd1;
    localparam logic [4:0] S_IVDIV  = 5'd2;
    localparam logic [4:0] S_ACC1   = 5'd3;
    localparam logic [4:0] S_ACC2   = 5'd4;
    localparam logic [4:0] S_CHECK  = 5'd5;
    localparam logic [4:0] S_MEAN   = 5'd6;
    localparam logic [4:0] S_PNPREP = 5'd7;
    localparam logic [4:0] S_PNDIV  = 5'd8;
    localparam logic [4:0] S_MUL1   = 5'd9;
    localparam logic [4:0] S_MUL2   = 5'd10;
    localparam logic [4:0] S_DSR    = 5'd11;
    localparam logic [4:0] S_SDDIV  = 5'd12;
    localparam logic [4:0] S_SDSQ   = 5'd13;
    localparam logic [4:0] S_RMDIV  = 5'd14;
    localparam logic [4:0] S_RMSQ   = 5'd15;
    localparam logic [4:0] S_EMIT   = 5'd16;

    logic [4:0]        r_state;
    logic [RATE_W-1:0] r_rate;
    logic [THR_W-1:0]  r_thr;

    // record state
    logic [PEAK_W-1:0] r_prev_peak;
    logic              r_have_prev;
    logic [IV_W-1:0]   r_prev_iv;
    logic [CNT_W-1:0]  r_total;
    logic [SUM_W-1:0]  r_sum;
    logic [SQS_W-1:0]  r_sqsum;
    logic [SQS_W-1:0]  r_ssq;
    logic [CNT_W-1:0]  r_hits;
    logic              r_ovf;

    // working registers
    logic              r_last;
    logic [PEAK_W-1:0] r_gap;
    logic [IV_W-1:0]   r_iv;
    logic [DVD_W-1:0]  r_dvd;
    logic [DSR_W-1:0]  r_dsr;
    logic [MUL_W-1:0]  r_ma;
    logic [MB_W-1:0]   r_mb;
    logic [MUL_W-1:0]  r_p1;
    logic [SQ_W-1:0]   r_sqv;
    logic              r_div_go;
    logic              r_mul_go;
    logic              r_sq_go;
    logic [IV_W-1:0]   r_mean;
    logic [PNN_W-1:0]  r_pn;
    logic [IV_W-1:0]   r_sd;

    // output register
    logic              r_o_valid;
    logic [IV_W-1:0]   r_o_mean;
    logic [IV_W-1:0]   r_o_sd;
    logic [IV_W-1:0]   r_o_rm;
    logic [CNT_W-1:0]  r_o_nn50;
    logic [PNN_W-1:0]  r_o_pn;
    logic [CNT_W-1:0]  r_o_cnt;
    logic              r_o_vres;
    logic              r_o_ovf;

    t_unit_stat        div_stat;
    t_unit_stat        mul_stat;
    t_unit_stat        sq_stat;
    logic [DVD_W-1:0]  div_quot;
    logic [MUL_W-1:0]  mul_prod;
    logic [IV_W-1:0]   sq_root;

    logic              accept;
    logic [RATE_W-1:0] rate_eff;
    logic [IV_W-1:0]   diff;
    logic              out_free;

    hrv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_dvd),
        .i_divisor  (r_dsr),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    hrv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_stat  (mul_stat),
        .o_prod  (mul_prod)
    );

    hrv_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_val   (r_sqv),
        .o_stat  (sq_stat),
        .o_root  (sq_root)
    );

    assign accept   = i_peak.valid && i_peak.ready;
    assign rate_eff = (r_rate == '0) ? RATE_W'(1) : r_rate;
    assign diff     = (r_iv > r_prev_iv) ? (r_iv - r_prev_iv) : (r_prev_iv - r_iv);
    assign out_free = !r_o_valid || o_stats.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_thr  <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAMPLE_RATE: r_rate <= i_cfg_data;
                REG_DIFF_THR:    r_thr  <= i_cfg_data[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_go    <= 1'b0;
            r_mul_go    <= 1'b0;
            r_sq_go     <= 1'b0;
            r_o_valid   <= 1'b0;
            r_prev_peak <= '0;
            r_have_prev <= 1'b0;
            r_prev_iv   <= '0;
            r_total     <= '0;
            r_sum       <= '0;
            r_sqsum     <= '0;
            r_ssq       <= '0;
            r_hits      <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_mul_go <= 1'b0;
            r_sq_go  <= 1'b0;
            // result taken; the emit state loads the register itself
            if (r_o_valid && o_stats.ready && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last      <= i_peak.last;
                        r_prev_peak <= i_peak.peak_sample;
                        r_have_prev <= 1'b1;
                        r_gap       <= i_peak.peak_sample - r_prev_peak;
                        if (r_have_prev && i_peak.peak_sample > r_prev_peak) begin
                            r_state <= S_IVMUL;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_IVMUL: begin
                    r_dvd    <= DVD_W'(46'(r_gap) * 46'(C_MS_SCALE) + 46'(rate_eff >> 1));
                    r_dsr    <= DSR_W'(rate_eff);
                    r_div_go <= 1'b1;
                    r_state  <= S_IVDIV;
                end
                S_IVDIV: begin
                    if (div_stat.done) begin
                        if (div_quot > DVD_W'(16'hFFFF)) begin
                            r_iv  <= 16'hFFFF;
                            r_ovf <= 1'b1;
                        end else begin
                            r_iv <= div_quot[IV_W-1:0];
                        end
                        r_state <= S_ACC1;
                    end
                end
                S_ACC1: begin
                    if (r_total >= CNT_W'(MAX_INTERVALS)) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_CHECK;
                    end else begin
                        // successive difference against the previous interval
                        if (r_total != '0) begin
                            r_ssq <= r_ssq + SQS_W'(32'(diff) * 32'(diff));
                            if (diff > {2'b00, r_thr, 4'b0000}) begin
                                r_hits <= r_hits + 1'b1;
                            end
                        end
                        r_state <= S_ACC2;
                    end
                end
                S_ACC2: begin
                    r_total   <= r_total + 1'b1;
                    r_sum     <= r_sum + SUM_W'(r_iv);
                    r_sqsum   <= r_sqsum + SQS_W'(32'(r_iv) * 32'(r_iv));
                    r_prev_iv <= r_iv;
                    r_state   <= S_CHECK;
                end
                S_CHECK: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_total == '0) begin
                        r_mean  <= '0;
                        r_pn    <= '0;
                        r_sd    <= '0;
                        r_p1    <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_dvd    <= DVD_W'(r_sum) + DVD_W'(r_total >> 1);
                        r_dsr    <= DSR_W'(r_total);
                        r_div_go <= 1'b1;
                        r_state  <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (div_stat.done) begin
                        r_mean  <= div_quot[IV_W-1:0];
                        r_state <= S_PNPREP;
                    end
                end
                S_PNPREP: begin
                    r_dvd    <= DVD_W'(31'(r_hits) * 31'(C_PCT_SCALE) + 31'(r_total >> 1));
                    r_dsr    <= DSR_W'(r_total);
                    r_div_go <= 1'b1;
                    r_state  <= S_PNDIV;
                end
                S_PNDIV: begin
                    if (div_stat.done) begin
                        r_pn <= div_quot[PNN_W-1:0];
                        if (r_total < CNT_W'(2)) begin
                            r_sd    <= '0;
                            r_p1    <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_ma     <= MUL_W'(r_sqsum);
                            r_mb     <= MB_W'(r_total);
                            r_mul_go <= 1'b1;
                            r_state  <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    if (mul_stat.done) begin
                        r_p1     <= mul_prod;
                        r_ma     <= MUL_W'(r_sum);
                        r_mb     <= r_sum;
                        r_mul_go <= 1'b1;
                        r_state  <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (mul_stat.done) begin
                        r_dvd   <= r_p1 - mul_prod;
                        r_state <= S_DSR;
                    end
                end
                S_DSR: begin
                    r_dsr    <= DSR_W'(34'(r_total) * 34'(r_total - 1'b1));
                    r_div_go <= 1'b1;
                    r_state  <= S_SDDIV;
                end
                S_SDDIV: begin
                    if (div_stat.done) begin
                        r_sqv   <= div_quot[SQ_W-1:0];
                        r_sq_go <= 1'b1;
                        r_state <= S_SDSQ;
                    end
                end
                S_SDSQ: begin
                    if (sq_stat.done) begin
                        r_sd     <= sq_root;
                        r_dvd    <= DVD_W'(r_ssq);
                        r_dsr    <= DSR_W'(r_total - 1'b1);
                        r_div_go <= 1'b1;
                        r_state  <= S_RMDIV;
                    end
                end
                S_RMDIV: begin
                    if (div_stat.done) begin
                        r_sqv   <= div_quot[SQ_W-1:0];
                        r_sq_go <= 1'b1;
                        r_state <= S_RMSQ;
                    end
                end
                S_RMSQ: begin
                    if (sq_stat.done) begin
                        r_p1    <= MUL_W'(sq_root);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // rmssd travels in the low bits of r_p1
                    if (out_free) begin
                        r_o_valid   <= 1'b1;
                        r_o_mean    <= r_mean;
                        r_o_sd      <= r_sd;
                        r_o_rm      <= r_p1[IV_W-1:0];
                        r_o_nn50    <= r_hits;
                        r_o_pn      <= r_pn;
                        r_o_cnt     <= r_total;
                        r_o_vres    <= r_total >= CNT_W'(2);
                        r_o_ovf     <= r_ovf;
                        r_prev_peak <= '0;
                        r_have_prev <= 1'b0;
                        r_prev_iv   <= '0;
                        r_total     <= '0;
                        r_sum       <= '0;
                        r_sqsum     <= '0;
                        r_ssq       <= '0;
                        r_hits      <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_peak.ready           = (r_state == S_IDLE);
    assign o_stats.valid          = r_o_valid;
    assign o_stats.mean_rr        = r_o_mean;
    assign o_stats.sdnn           = r_o_sd;
    assign o_stats.rmssd          = r_o_rm;
    assign o_stats.nn50           = r_o_nn50;
    assign o_stats.pnn50          = r_o_pn;
    assign o_stats.interval_count = r_o_cnt;
    assign o_stats.valid_res      = r_o_vres;
    assign o_stats.overflow       = r_o_ovf;

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_INTERVALS)) else $error("interval count beyond capacity");
    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits <= r_total) else $error("more threshold hits than intervals");
    a_short_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_vres |-> r_o_sd == '0 && r_o_rm == '0)
        else $error("deviation reported for a record under two intervals");
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({div_stat.busy, mul_stat.busy, sq_stat.busy}) <= 1)
        else $error("two arithmetic units running at once");
endmodule

// ===== dv/hrv_time_domain_stats_test.sv =====
module hrv_time_domain_stats_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrv_pkg::*;

    // one statistics result as the receiver sees it
    typedef struct packed {
        logic [IV_W-1:0]  mean_rr;
        logic [IV_W-1:0]  sdnn;
        logic [IV_W-1:0]  rmssd;
        logic [CNT_W-1:0] nn50;
        logic [PNN_W-1:0] pnn50;
        logic [CNT_W-1:0] interval_count;
        logic             valid_res;
        logic             overflow;
    } t_hrv_stats;

    typedef enum logic [1:0] {
        ROW_PEAK,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [PEAK_W-1:0] peak;
        logic              last;
        logic              typed;
        t_hrv_stats        want;
        logic [CFG_IDX_W-1:0] idx;
        logic [RATE_W-1:0] data;
    } t_row;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int LONG_HOLD      = 2500;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [RATE_W-1:0]    i_cfg_data;

    hrv_peak_if  peak_ch ();
    hrv_stats_if stats_ch ();

    hrv_time_domain_stats dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_peak     (peak_ch),
        .o_stats    (stats_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state and configuration copy
    logic [RATE_W-1:0] rate_cfg;
    logic [THR_W-1:0]  thr_cfg;
    logic [PEAK_W-1:0] last_peak;
    logic              have_peak;
    logic [IV_W-1:0]   last_iv;
    longint unsigned   iv_count;
    longint unsigned   iv_sum;
    longint unsigned   iv_sq_sum;
    longint unsigned   diff_sq_sum;
    longint unsigned   hits;
    logic              sat_seen;

    t_hrv_stats expected_stats[$];
    int errors;
    int peaks_sent;
    int records_seen;
    int saturated_records;
    logic long_hold_req;
    logic idle_en;
    int quiet_cycles;

    function automatic void clear_record();
        last_peak   = '0;
        have_peak   = 1'b0;
        last_iv     = '0;
        iv_count    = 0;
        iv_sum      = 0;
        iv_sq_sum   = 0;
        diff_sq_sum = 0;
        hits        = 0;
        sat_seen    = 1'b0;
    endfunction

    // integer square root rounded to nearest, clipped to 16 bits
    function automatic longint unsigned round_root(longint unsigned v);
        longint unsigned r, b, x;
        r = 0;
        b = 64'd1 << 62;
        x = v;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (v - r * r > r)
            r++;
        return (r > 65535) ? 65535 : r;
    endfunction

    // fold one peak into the record; returns 1 when a result is due
    function automatic logic fold_peak(logic [PEAK_W-1:0] peak, logic last,
                                       output t_hrv_stats res);
        longint unsigned gap, rate, iv, d, mean, sd, rm, pn;
        logic [127:0] num, den;
        res = '0;
        if (have_peak && peak > last_peak) begin
            gap  = peak - last_peak;
            rate = (rate_cfg == 0) ? 1 : rate_cfg;
            iv   = (gap * 16000 + rate / 2) / rate;
            if (iv > 65535) begin
                iv = 65535;
                sat_seen = 1'b1;
            end
            if (iv_count >= MAX_INTERVALS) begin
                sat_seen = 1'b1;
            end else begin
                if (iv_count >= 1) begin
                    d = (iv > last_iv) ? iv - last_iv : last_iv - iv;
                    diff_sq_sum += d * d;
                    if (d > longint'(thr_cfg) * 16)
                        hits++;
                end
                iv_count++;
                iv_sum    += iv;
                iv_sq_sum += iv * iv;
                last_iv   = iv[IV_W-1:0];
            end
        end
        last_peak = peak;
        have_peak = 1'b1;
        if (!last)
            return 1'b0;

        mean = 0;
        sd   = 0;
        rm   = 0;
        pn   = 0;
        if (iv_count >= 1) begin
            mean = (iv_sum + iv_count / 2) / iv_count;
            pn   = (hits * 10000 + iv_count / 2) / iv_count;
        end
        if (iv_count >= 2) begin
            num = 128'(iv_count) * 128'(iv_sq_sum) - 128'(iv_sum) * 128'(iv_sum);
            den = 128'(iv_count * (iv_count - 1));
            sd  = round_root(64'(num / den));
            rm  = round_root(diff_sq_sum / (iv_count - 1));
        end
        res.mean_rr        = mean[IV_W-1:0];
        res.sdnn           = sd[IV_W-1:0];
        res.rmssd          = rm[IV_W-1:0];
        res.nn50           = hits[CNT_W-1:0];
        res.pnn50          = pn[PNN_W-1:0];
        res.interval_count = iv_count[CNT_W-1:0];
        res.valid_res      = (iv_count >= 2);
        res.overflow       = sat_seen;
        clear_record();
        return 1'b1;
    endfunction

    // send one peak request, then fold it once accepted
    task automatic send_peak(logic [PEAK_W-1:0] peak, logic last, logic typed,
                             t_hrv_stats want);
        int gap;
        t_hrv_stats res;
        gap = 0;
        if (idle_en) begin
            case ($urandom_range(19))
                0, 1, 2, 3:  gap = $urandom_range(1, 3);
                4:           gap = $urandom_range(20, 80);
                default:     gap = 0;
            endcase
        end
        if (gap > 0) begin
            peak_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        peak_ch.valid       = 1'b1;
        peak_ch.peak_sample = peak;
        peak_ch.last        = last;
        do
            @(posedge i_clk);
        while (!peak_ch.ready);
        peaks_sent++;
        if (fold_peak(peak, last, res))
            expected_stats.insert(expected_stats.size(), typed ? want : res);
        @(negedge i_clk);
        peak_ch.valid = 1'b0;
    endtask

    // register write while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
        wait (expected_stats.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_SAMPLE_RATE)
            rate_cfg = data;
        else if (idx == REG_DIFF_THR)
            thr_cfg = data[THR_W-1:0];
    endtask

    // one record of peaks with random spacing, mostly well formed
    task automatic send_record(int len);
        logic [PEAK_W-1:0] pos;
        int unsigned span;
        t_hrv_stats none;
        none = '0;
        pos  = $urandom;
        span = (rate_cfg == 0) ? 1 : rate_cfg;
        for (int k = 0; k < len; k++) begin
            send_peak(pos, k == len - 1, 1'b0, none);
            case ($urandom_range(19))
                0:       pos = pos - $urandom_range(0, 50);
                1:       pos = pos + $urandom;
                default: pos = pos + $urandom_range(span / 3 + 1, span * 2);
            endcase
        end
    endtask

    // receiver ready with random stalls and one long hold
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            stats_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD;
            stats_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            stats_ch.ready <= 1'b0;
        end else if (idle_en && $urandom_range(5) == 0) begin
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 5);
            stats_ch.ready <= 1'b0;
        end else begin
            stats_ch.ready <= 1'b1;
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_hrv_stats want;
        if (i_rst_n && stats_ch.valid && stats_ch.ready) begin
            if (expected_stats.size() == 0) begin
                $error("result request with nothing expected");
                errors++;
            end else begin
                want = expected_stats.pop_front();
                records_seen++;
                if (stats_ch.overflow)
                    saturated_records++;
                check_field("mean_rr", want.mean_rr, stats_ch.mean_rr);
                check_field("sdnn", want.sdnn, stats_ch.sdnn);
                check_field("rmssd", want.rmssd, stats_ch.rmssd);
                check_field("nn50", want.nn50, stats_ch.nn50);
                check_field("pnn50", want.pnn50, stats_ch.pnn50);
                check_field("interval_count", want.interval_count,
                            stats_ch.interval_count);
                check_field("valid_res", want.valid_res, stats_ch.valid_res);
                check_field("overflow", want.overflow, stats_ch.overflow);
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge i_clk) begin
        if ((peak_ch.valid && peak_ch.ready) || (stats_ch.valid && stats_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    t_row rows[$];

    function automatic void add_row(t_row r);
        rows.insert(rows.size(), r);
    endfunction

    function automatic t_row peak_row(logic [PEAK_W-1:0] peak, logic last);
        t_row r;
        r = '{kind: ROW_PEAK, peak: peak, last: last, typed: 1'b0, want: '0,
              idx: '0, data: '0};
        return r;
    endfunction

    function automatic t_row typed_row(logic [PEAK_W-1:0] peak, t_hrv_stats want);
        t_row r;
        r = peak_row(peak, 1'b1);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
        t_row r;
        r = '{kind: ROW_CFG, peak: '0, last: 1'b0, typed: 1'b0, want: '0,
              idx: idx, data: data};
        return r;
    endfunction

    initial begin
        t_hrv_stats none, sat_one, flat_three;
        int phase_rate;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = REG_SAMPLE_RATE;
        i_cfg_data          = '0;
        peak_ch.valid       = 1'b0;
        peak_ch.peak_sample = '0;
        peak_ch.last        = 1'b0;
        errors              = 0;
        peaks_sent          = 0;
        records_seen        = 0;
        saturated_records   = 0;
        long_hold_req       = 1'b0;
        idle_en             = 1'b1;
        quiet_cycles        = 0;
        rate_cfg            = RATE_RESET;
        thr_cfg             = THR_RESET;
        clear_record();

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // record with no interval, one saturated interval, three equal intervals
        none       = '0;
        sat_one    = '0;
        sat_one.mean_rr        = 16'hFFFF;
        sat_one.interval_count = CNT_W'(1);
        sat_one.overflow       = 1'b1;
        flat_three = '0;
        flat_three.mean_rr        = IV_W'(16000);
        flat_three.interval_count = CNT_W'(3);
        flat_three.valid_res      = 1'b1;

        // directed stimulus table
        add_row(typed_row(32'd1000, none));
        add_row(peak_row(32'd0, 1'b0));
        add_row(typed_row(32'hFFFF_FFFF, sat_one));
        add_row(peak_row(32'd500, 1'b0));
        add_row(peak_row(32'd400, 1'b0));
        add_row(typed_row(32'd400, none));
        add_row(peak_row(32'd0, 1'b0));
        add_row(peak_row(32'd360, 1'b0));
        add_row(peak_row(32'd720, 1'b0));
        add_row(typed_row(32'd1080, flat_three));
        add_row(cfg_row(REG_DIFF_THR, 12'd0));
        add_row(peak_row(32'd0, 1'b0));
        add_row(peak_row(32'd360, 1'b0));
        add_row(peak_row(32'd370, 1'b0));
        add_row(peak_row(32'd1000, 1'b1));
        add_row(cfg_row(REG_SAMPLE_RATE, 12'd4095));
        add_row(cfg_row(REG_DIFF_THR, 12'hFFF));
        add_row(peak_row(32'd100, 1'b0));
        add_row(peak_row(32'd4195, 1'b0));
        add_row(peak_row(32'd5000, 1'b0));
        add_row(peak_row(32'd9000, 1'b0));
        add_row(peak_row(32'd9001, 1'b1));
        add_row(cfg_row(2'd2, 12'd7));
        add_row(cfg_row(2'd3, 12'hABC));
        add_row(cfg_row(REG_SAMPLE_RATE, 12'd0));
        add_row(peak_row(32'd10, 1'b0));
        add_row(peak_row(32'd12, 1'b0));
        add_row(peak_row(32'd13, 1'b1));
        add_row(cfg_row(REG_SAMPLE_RATE, 12'd1));
        add_row(peak_row(32'h8000_0000, 1'b0));
        add_row(peak_row(32'h8000_0003, 1'b0));
        add_row(peak_row(32'h8000_0004, 1'b1));
        add_row(cfg_row(REG_SAMPLE_RATE, RATE_RESET));
        add_row(cfg_row(REG_DIFF_THR, 12'(THR_RESET)));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                write_reg(rows[i].idx, rows[i].data);
            else
                send_peak(rows[i].peak, rows[i].last, rows[i].typed, rows[i].want);
        end

        // random phases: each picks a setting, then a run of records
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       phase_rate = 360;
                1:       phase_rate = 4095;
                2:       phase_rate = 1;
                default: phase_rate = $urandom_range(100, 1000);
            endcase
            write_reg(REG_SAMPLE_RATE, RATE_W'(phase_rate));
            case (ph % 3)
                0:       write_reg(REG_DIFF_THR, RATE_W'($urandom_range(0, 4095)));
                1:       write_reg(REG_DIFF_THR, (ph == 1) ? 12'h3FF : 12'h400);
                default: write_reg(REG_DIFF_THR, RATE_W'($urandom_range(0, 100)));
            endcase
            idle_en = (ph != 4);
            if (ph == 3)
                long_hold_req = 1'b1;
            while (peaks_sent < 40 + (ph + 1) * 45) begin
                send_record(($urandom_range(9) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 8));
            end
        end

        // drain
        wait (expected_stats.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d peak requests and %0d records, %0d of them saturated",
                 peaks_sent, records_seen, saturated_records);
        $display("register settings included rate 0, 1 and 4095 and threshold 0 and 1023");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== hrv_time_domain_stats.f =====
src/hrv_pkg.sv
src/hrv_peak_if.sv
src/hrv_stats_if.sv
src/hrv_div.sv
src/hrv_mul.sv
src/hrv_sqrt.sv
src/hrv_time_domain_stats.sv
dv/hrv_time_domain_stats_test.sv
